// File: rtl/slice_group_map_unit_macros.svh
// Assertion helpers shared by the RTL
`ifndef SLICE_GROUP_MAP_UNIT_MACROS_SVH
`define SLICE_GROUP_MAP_UNIT_MACROS_SVH

// Same-cycle implication
`define SGMU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slice group map: implication check failed");

// Next-cycle implication
`define SGMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slice group map: next-cycle check failed");

`endif

// File: rtl/sgmu_pkg.sv
package sgmu_pkg;

   // field widths
   localparam int UNIT_W     = 16;
   localparam int GRP_W      = 3;
   localparam int MODE_W     = 2;
   localparam int KIND_W     = 3;
   localparam int WID_W      = 11;
   localparam int PIC_W      = 17;
   localparam int CNT_W      = 4;
   localparam int DIV_W      = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // item modes
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RECT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   // map kinds
   localparam logic [KIND_W-1:0] KIND_INTERLEAVED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DISPERSED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FOREGROUND  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXPLICIT    = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_KIND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_UNITS   = 2'd3;

   // floor(2^16 / c) for small modulo by reciprocal, indexed by c
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_SHIFT-1:0] MOD_RECIP [9] =
      '{16'd0, 16'd0, 16'd32768, 16'd21845, 16'd16384,
        16'd13107, 16'd10922, 16'd9362, 16'd8192};

   typedef logic [UNIT_W-1:0] unit_type;
   typedef logic [GRP_W-1:0]  group_type;
   typedef logic [MODE_W-1:0] mode_type;

endpackage

// File: rtl/sgmu_channels.sv
// Request channel: loads and queries
interface sgmu_req_if import sgmu_pkg::*; ();
   logic      valid;
   logic      ready;
   mode_type  mode;
   group_type group_index;
   unit_type  run_span;
   unit_type  first_corner_unit;
   unit_type  last_corner_unit;
   unit_type  unit_index;
   group_type explicit_group;

   modport source (output valid, mode, group_index, run_span, first_corner_unit,
                   last_corner_unit, unit_index, explicit_group, input ready);
   modport sink   (input valid, mode, group_index, run_span, first_corner_unit,
                   last_corner_unit, unit_index, explicit_group, output ready);
endinterface

// Response channel: one item per query
interface sgmu_rsp_if import sgmu_pkg::*; ();
   logic      valid;
   logic      ready;
   group_type slice_group;
   logic      index_beyond_picture;

   modport source (output valid, slice_group, index_beyond_picture, input ready);
   modport sink   (input valid, slice_group, index_beyond_picture, output ready);
endinterface

// File: rtl/slice_group_map_unit.sv
// Channel  Port      Direction  Content
// request  req_if    in         load run / load rectangle / query map unit
// response rsp_if    out        slice group and beyond-picture flag
// config   csr_*     in         write enable, register index, write data
//
// One item enters per cycle unless the output stalls the full pipeline.
// Latency is set mostly by the 16-stage restoring divider, one quotient bit a stage.
// Loads update the stores on acceptance and produce no response.
// Reset clears the valid bits and loads the config defaults; the stores stay unset.
// A stage holds when the next one is full and stalled; bubbles are squeezed out.
`include "slice_group_map_unit_macros.svh"

module slice_group_map_unit import sgmu_pkg::*; #(
   parameter int MAX_MAP_UNITS = 65536,
   parameter int MAX_GROUPS    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   sgmu_req_if.sink              req_if,
   sgmu_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int G    = MAX_GROUPS;
   localparam int GI_W = $clog2(G);
   localparam int L    = 2 * G;
   localparam int DSTG = UNIT_W;
   localparam int NS   = DSTG + 4;
   localparam int PW   = WID_W + RECIP_SHIFT;

   // configuration
   logic [GRP_W-1:0]  group_count_ff;
   logic [KIND_W-1:0] map_kind_ff;
   logic [WID_W-1:0]  width_ff;
   logic [PIC_W-1:0]  pic_units_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff <= '0;
         map_kind_ff    <= KIND_INTERLEAVED;
         width_ff       <= WID_W'(1);
         pic_units_ff   <= PIC_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GROUP_COUNT: group_count_ff <= csr_wdata[GRP_W-1:0];
            CSR_MAP_KIND:    map_kind_ff    <= csr_wdata[KIND_W-1:0];
            CSR_WIDTH:       width_ff       <= csr_wdata[WID_W-1:0];
            CSR_PIC_UNITS:   pic_units_ff   <= csr_wdata[PIC_W-1:0];
            default:         ;
         endcase
      end
   end

   // effective group count, width and picture size
   logic [CNT_W-1:0] n_eff;
   logic [WID_W-1:0] w_eff;
   logic [PIC_W-1:0] pic_eff;

   always_comb begin
      n_eff = {1'b0, group_count_ff} + CNT_W'(1);
      if (n_eff > CNT_W'(G)) n_eff = CNT_W'(G);
      w_eff   = (width_ff == '0) ? WID_W'(1) : width_ff;
      pic_eff = (pic_units_ff > PIC_W'(MAX_MAP_UNITS)) ? PIC_W'(MAX_MAP_UNITS)
                                                       : pic_units_ff;
   end

   // stage flow control
   logic          v_ff [NS];
   logic [NS:0]   adv;
   logic          req_acc;

   always_comb begin
      adv[NS] = rsp_if.ready;
      for (int i = NS - 1; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
   end

   assign req_if.ready = adv[0];
   assign req_acc      = req_if.valid && adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else begin
         if (adv[0]) v_ff[0] <= req_acc && (req_if.mode == MODE_QUERY);
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // run and rectangle stores
   unit_type run_ff   [G];
   unit_type first_ff [G-1];
   unit_type last_ff  [G-1];

   always_ff @(posedge clock) begin
      if (req_acc && req_if.mode == MODE_RUN &&
          {1'b0, req_if.group_index} < (GRP_W+1)'(G)) begin
         run_ff[req_if.group_index[GI_W-1:0]] <= req_if.run_span;
      end
      if (req_acc && req_if.mode == MODE_RECT &&
          {1'b0, req_if.group_index} < (GRP_W+1)'(G - 1)) begin
         first_ff[req_if.group_index[GI_W-1:0]] <= req_if.first_corner_unit;
         last_ff[req_if.group_index[GI_W-1:0]]  <= req_if.last_corner_unit;
      end
   end

   // stage A: capture the query and a snapshot of the stores
   unit_type  a_unit_ff;
   group_type a_expl_ff;
   logic      a_beyond_ff;
   unit_type  a_run_ff   [G];
   unit_type  a_first_ff [G-1];
   unit_type  a_last_ff  [G-1];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_unit_ff   <= req_if.unit_index;
         a_expl_ff   <= req_if.explicit_group;
         a_beyond_ff <= {1'b0, req_if.unit_index} >= pic_eff;
         a_run_ff    <= run_ff;
         a_first_ff  <= first_ff;
         a_last_ff   <= last_ff;
      end
   end

   // prefix sums of run lengths
   logic [DIV_W-1:0] cum_in [G];
   logic [DIV_W-1:0] tot_in;
   logic [DIV_W-1:0] acc;

   always_comb begin
      acc = '0;
      for (int g = 0; g < G; g++) begin
         acc       = acc + DIV_W'(a_run_ff[g]) + DIV_W'(1);
         cum_in[g] = acc;
      end
      tot_in = cum_in[GI_W'(n_eff - CNT_W'(1))];
   end

   // divider rows: entry 0 is the load row, entry j holds j quotient bits.
   // lane 0 unit, lanes 1..G-1 first corners, G..2G-2 last corners,
   // last lane unit over the total run length
   logic [DIV_W-1:0] r_rem_ff    [DSTG+1][L];
   unit_type         r_dq_ff     [DSTG+1][L];
   logic [DIV_W-1:0] r_tot_ff    [DSTG+1];
   logic [DIV_W-1:0] r_cum_ff    [DSTG+1][G];
   group_type        r_expl_ff   [DSTG+1];
   logic             r_beyond_ff [DSTG+1];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int l = 0; l < L; l++) r_rem_ff[0][l] <= '0;
         r_dq_ff[0][0]   <= a_unit_ff;
         r_dq_ff[0][L-1] <= a_unit_ff;
         for (int g = 0; g < G - 1; g++) begin
            r_dq_ff[0][1+g] <= a_first_ff[g];
            r_dq_ff[0][G+g] <= a_last_ff[g];
         end
         r_tot_ff[0]    <= tot_in;
         r_cum_ff[0]    <= cum_in;
         r_expl_ff[0]   <= a_expl_ff;
         r_beyond_ff[0] <= a_beyond_ff;
      end
   end

   for (genvar j = 0; j < DSTG; j++) begin : g_div
      logic [DIV_W-1:0] nx_rem [L];
      unit_type         nx_dq  [L];

      // one restoring step on every lane
      always_comb begin
         logic [DIV_W:0]   t;
         logic [DIV_W:0]   dv;
         logic [DIV_W:0]   diff;
         logic             ge;
         for (int l = 0; l < L; l++) begin
            t  = {r_rem_ff[j][l], r_dq_ff[j][l][UNIT_W-1]};
            dv = (l == L - 1) ? {1'b0, r_tot_ff[j]} : (DIV_W+1)'(w_eff);
            ge = t >= dv;
            diff = t - dv;
            nx_rem[l] = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
            nx_dq[l]  = {r_dq_ff[j][l][UNIT_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j+2]) begin
            r_rem_ff[j+1]    <= nx_rem;
            r_dq_ff[j+1]     <= nx_dq;
            r_tot_ff[j+1]    <= r_tot_ff[j];
            r_cum_ff[j+1]    <= r_cum_ff[j];
            r_expl_ff[j+1]   <= r_expl_ff[j];
            r_beyond_ff[j+1] <= r_beyond_ff[j];
         end
      end
   end

   // stage P1: rectangle and run hits, reciprocal products for ux mod n
   logic [WID_W-1:0] p1_ux_ff;
   logic             p1_uy0_ff;
   logic [PW-1:0]    p1_prod_ff [G-1];
   logic [G-2:0]     p1_rect_hit_ff;
   logic [G-1:0]     p1_run_hit_ff;
   group_type        p1_expl_ff;
   logic             p1_beyond_ff;

   logic [G-2:0]     rect_hit;
   logic [G-1:0]     run_hit;
   logic [WID_W-1:0] ux;
   unit_type         uy;

   always_comb begin
      logic [DIV_W-1:0] xt;
      logic [DIV_W-1:0] xb;
      unit_type         yt;
      unit_type         yb;
      ux = r_rem_ff[DSTG][0][WID_W-1:0];
      uy = r_dq_ff[DSTG][0];
      for (int g = 0; g < G - 1; g++) begin
         xt = r_rem_ff[DSTG][1+g];
         yt = r_dq_ff[DSTG][1+g];
         xb = r_rem_ff[DSTG][G+g];
         yb = r_dq_ff[DSTG][G+g];
         rect_hit[g] = (DIV_W'(ux) >= xt) && (DIV_W'(ux) <= xb) &&
                       (uy >= yt) && (uy <= yb);
      end
      for (int g = 0; g < G; g++) begin
         run_hit[g] = r_cum_ff[DSTG][g] > r_rem_ff[DSTG][L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NS-2]) begin
         p1_ux_ff  <= ux;
         p1_uy0_ff <= uy[0];
         for (int c = 2; c <= G; c++) begin
            p1_prod_ff[c-2] <= PW'(ux) * PW'(MOD_RECIP[c]);
         end
         p1_rect_hit_ff <= rect_hit;
         p1_run_hit_ff  <= run_hit;
         p1_expl_ff     <= r_expl_ff[DSTG];
         p1_beyond_ff   <= r_beyond_ff[DSTG];
      end
   end

   // stage P2: finish ux mod n and pick the group
   group_type grp_in;

   always_comb begin
      logic [GI_W-1:0]        ridx;
      logic [WID_W-1:0]       q;
      logic [WID_W+CNT_W-1:0] qn;
      logic [WID_W-1:0]       xm;
      logic [WID_W-1:0]       disp;
      group_type              last_grp;
      ridx = (n_eff > CNT_W'(1)) ? GI_W'(n_eff - CNT_W'(2)) : '0;
      q    = p1_prod_ff[ridx][PW-1:RECIP_SHIFT];
      qn   = (WID_W+CNT_W)'(q) * (WID_W+CNT_W)'(n_eff);
      xm   = p1_ux_ff - qn[WID_W-1:0];
      if (xm >= WID_W'(n_eff)) xm = xm - WID_W'(n_eff);
      // odd rows shift by floor(n/2)
      disp = xm + (p1_uy0_ff ? WID_W'(n_eff >> 1) : '0);
      if (disp >= WID_W'(n_eff)) disp = disp - WID_W'(n_eff);
      last_grp = GRP_W'(n_eff - CNT_W'(1));

      grp_in = '0;
      if (!p1_beyond_ff && n_eff > CNT_W'(1)) begin
         case (map_kind_ff)
            KIND_INTERLEAVED: begin
               grp_in = last_grp;
               for (int g = G - 1; g >= 0; g--) begin
                  if (CNT_W'(g) < n_eff && p1_run_hit_ff[g]) grp_in = GRP_W'(g);
               end
            end
            KIND_DISPERSED: grp_in = disp[GRP_W-1:0];
            KIND_FOREGROUND: begin
               grp_in = last_grp;
               for (int g = G - 2; g >= 0; g--) begin
                  if (CNT_W'(g + 1) < n_eff && p1_rect_hit_ff[g]) grp_in = GRP_W'(g);
               end
            end
            KIND_EXPLICIT: grp_in = p1_expl_ff;
            default:       grp_in = '0;
         endcase
      end
   end

   group_type o_group_ff;
   logic      o_beyond_ff;

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         o_group_ff  <= grp_in;
         o_beyond_ff <= p1_beyond_ff;
      end
   end

   assign rsp_if.valid                = v_ff[NS-1];
   assign rsp_if.slice_group          = o_group_ff;
   assign rsp_if.index_beyond_picture = o_beyond_ff;

   // checks
   `SGMU_ASSERT_IMP(a_beyond_zero, clock, reset,
      rsp_if.valid && rsp_if.index_beyond_picture, rsp_if.slice_group == '0)
   `SGMU_ASSERT_IMP(a_ready_only_on_full_stall, clock, reset,
      !req_if.ready, rsp_if.valid && !rsp_if.ready)
   `SGMU_ASSERT_NEXT(a_load_no_entry, clock, reset,
      req_if.valid && req_if.ready && req_if.mode != MODE_QUERY, !v_ff[0])

endmodule

// File: tb/slice_group_map_unit_tb.sv
`timescale 1ns / 1ps

import sgmu_pkg::*;

typedef struct {
   mode_type  mode;
   group_type group_index;
   unit_type  run_span;
   unit_type  first_corner_unit;
   unit_type  last_corner_unit;
   unit_type  unit_index;
   group_type explicit_group;
} map_item_type;

typedef struct {
   group_type slice_group;
   logic      beyond;
} group_answer_type;

// Slice group predictor plus the queue of answers still owed by the block
class group_map_board;
   logic [GRP_W-1:0]  group_count_m1;
   logic [KIND_W-1:0] kind;
   logic [WID_W-1:0]  width;
   logic [PIC_W-1:0]  pic_units;
   logic [UNIT_W-1:0] run_len [8];
   logic [UNIT_W-1:0] rect_tl [7];
   logic [UNIT_W-1:0] rect_br [7];
   group_answer_type  owed [$];
   int                mismatches;
   int                answers;

   function new();
      group_count_m1 = '0;
      kind           = KIND_INTERLEAVED;
      width          = WID_W'(1);
      pic_units      = PIC_W'(1);
      mismatches     = 0;
      answers        = 0;
      foreach (run_len[g]) run_len[g] = '0;
      foreach (rect_tl[g]) begin
         rect_tl[g] = '0;
         rect_br[g] = '0;
      end
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_GROUP_COUNT: group_count_m1 = data[GRP_W-1:0];
         CSR_MAP_KIND:    kind = data[KIND_W-1:0];
         CSR_WIDTH:       width = data[WID_W-1:0];
         CSR_PIC_UNITS:   pic_units = data[PIC_W-1:0];
         default: ;
      endcase
   endfunction

   function int unsigned group_of(int unsigned u, int unsigned xg);
      int unsigned n, w, total, acc, ux, uy, tx, ty, bx, by, off;
      n = group_count_m1 + 1;
      w = (width == 0) ? 1 : width;
      if (n == 1) return 0;
      case (kind)
         KIND_INTERLEAVED: begin
            total = 0;
            for (int g = 0; g < n; g++) total += run_len[g] + 1;
            off = u % total;
            acc = 0;
            for (int g = 0; g < n; g++) begin
               acc += run_len[g] + 1;
               if (acc > off) return g;
            end
            return n - 1;
         end
         KIND_DISPERSED: return ((u % w) + ((u / w) * n) / 2) % n;
         KIND_FOREGROUND: begin
            ux = u % w;
            uy = u / w;
            for (int g = 0; g + 1 < n; g++) begin
               tx = rect_tl[g] % w;
               ty = rect_tl[g] / w;
               bx = rect_br[g] % w;
               by = rect_br[g] / w;
               if (ux >= tx && ux <= bx && uy >= ty && uy <= by) return g;
            end
            return n - 1;
         end
         KIND_EXPLICIT: return xg;
         default: return 0;
      endcase
   endfunction

   // Accepted request: update stores or queue the expected answer
   function void note_item(map_item_type it);
      group_answer_type a;
      int unsigned      pic;
      case (it.mode)
         MODE_RUN: run_len[it.group_index] = it.run_span;
         MODE_RECT: if (it.group_index < 7) begin
            rect_tl[it.group_index] = it.first_corner_unit;
            rect_br[it.group_index] = it.last_corner_unit;
         end
         MODE_QUERY: begin
            pic = (pic_units > 65536) ? 65536 : pic_units;
            if (it.unit_index >= pic) begin
               a.slice_group = '0;
               a.beyond      = 1'b1;
            end else begin
               a.slice_group = GRP_W'(group_of(it.unit_index, it.explicit_group));
               a.beyond      = 1'b0;
            end
            owed.push_back(a);
         end
         default: ;
      endcase
   endfunction

   function void check_answer(group_type grp, logic flag);
      group_answer_type e;
      answers++;
      if (owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR %0t: unexpected answer group=%0d beyond=%0b", $time, grp, flag);
         return;
      end
      e = owed.pop_front();
      if (grp !== e.slice_group || flag !== e.beyond) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR %0t: group exp %0d got %0d, beyond exp %0b got %0b",
                     $time, e.slice_group, grp, e.beyond, flag);
      end
   endfunction
endclass

module slice_group_map_unit_tb;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GROUP_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sgmu_req_if req_ch ();
   sgmu_rsp_if rsp_ch ();

   slice_group_map_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   group_map_board board = new();

   bit calm = 0;        // no random idling while set
   bit hold_req = 0;    // asks the receiver for one long hold-off
   int hold_left = 0;
   int cycles = 0;
   int loads_sent = 0;
   int queries_sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: check on the rising edge, ready changes on the falling edge
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_answer(rsp_ch.slice_group, rsp_ch.index_beyond_picture);

   initial rsp_ch.ready = 0;
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_left = 300;
      end
      if (reset) rsp_ch.ready <= 0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 0;
      end else rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   initial begin
      req_ch.valid             = 0;
      req_ch.mode              = MODE_RUN;
      req_ch.group_index       = '0;
      req_ch.run_span          = '0;
      req_ch.first_corner_unit = '0;
      req_ch.last_corner_unit  = '0;
      req_ch.unit_index        = '0;
      req_ch.explicit_group    = '0;
   end

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(map_item_type it);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid             <= 1;
      req_ch.mode              <= it.mode;
      req_ch.group_index       <= it.group_index;
      req_ch.run_span          <= it.run_span;
      req_ch.first_corner_unit <= it.first_corner_unit;
      req_ch.last_corner_unit  <= it.last_corner_unit;
      req_ch.unit_index        <= it.unit_index;
      req_ch.explicit_group    <= it.explicit_group;
      do @(posedge clock); while (!req_ch.ready);
      board.note_item(it);
      if (it.mode == MODE_QUERY) queries_sent++;
      else loads_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned gc, int unsigned kd, int unsigned wd,
                             int unsigned pc);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx = '{CSR_GROUP_COUNT, CSR_MAP_KIND, CSR_WIDTH, CSR_PIC_UNITS};
      val = '{CSR_DATA_W'(gc), CSR_DATA_W'(kd), CSR_DATA_W'(wd), CSR_DATA_W'(pc)};
      drain();
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_wr_en <= 1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         board.set_reg(idx[i], val[i]);
      end
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic map_item_type make_item(mode_type m, int unsigned g, int unsigned a,
                                              int unsigned b, int unsigned u);
      map_item_type it;
      it.mode              = m;
      it.group_index       = GRP_W'(g);
      it.run_span          = UNIT_W'($urandom);
      it.first_corner_unit = UNIT_W'($urandom);
      it.last_corner_unit  = UNIT_W'($urandom);
      it.unit_index        = UNIT_W'(u);
      it.explicit_group    = GRP_W'($urandom);
      if (m == MODE_RUN) it.run_span = UNIT_W'(a);
      if (m == MODE_RECT) begin
         it.first_corner_unit = UNIT_W'(a);
         it.last_corner_unit  = UNIT_W'(b);
      end
      return it;
   endfunction

   // random item: mostly queries inside the picture, some loads and noise
   function automatic map_item_type random_item();
      int unsigned r, pic, u;
      r   = $urandom_range(0, 99);
      pic = (board.pic_units > 65536) ? 65536 : board.pic_units;
      if (pic > 0 && $urandom_range(0, 99) < 80) u = $urandom_range(0, pic - 1);
      else u = $urandom_range(0, 65535);
      if (r < 10)
         return make_item(MODE_RUN, $urandom_range(0, 7),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 40), 0, u);
      if (r < 20)
         return make_item(MODE_RECT, $urandom_range(0, 7), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), u);
      if (r < 24) return make_item(mode_type'(2'd3), $urandom_range(0, 7), 0, 0, u);
      return make_item(MODE_QUERY, 0, 0, 0, u);
   endfunction

   initial begin
      int unsigned gc_set [10] = '{1, 7, 3, 0, 7, 2, 5, 7, 4, 6};
      int unsigned kd_set [10] = '{0, 1, 2, 6, 0, 2, 1, 3, 7, 5};
      int unsigned wd_set [10] = '{11, 1024, 7, 0, 2047, 1, 30, 45, 3, 1024};
      int unsigned pc_set [10] = '{99, 65536, 200, 0, 131071, 1, 1500, 65535, 70000, 5};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: fill every store entry, extremes, ignored loads and mode 3
      calm = 1;
      for (int g = 0; g < 8; g++)
         send_item(make_item(MODE_RUN, g, (g == 0) ? 0 : (g == 7) ? 65535 : g * 3, 0, 0));
      for (int g = 0; g < 7; g++)
         send_item(make_item(MODE_RECT, g, g * 3, (g == 0) ? 65535 : g * 40, 0));
      send_item(make_item(MODE_RECT, 7, 65535, 65535, 0));
      send_item(make_item(mode_type'(2'd3), 7, 0, 0, 65535));
      send_item(make_item(MODE_QUERY, 0, 0, 0, 0));
      send_item(make_item(MODE_QUERY, 0, 0, 0, 65535));
      send_item(make_item(MODE_QUERY, 0, 0, 0, 1));
      // empty rectangle on group 1 (left column past right)
      send_item(make_item(MODE_RECT, 1, 9, 2, 0));
      calm = 0;

      for (int p = 0; p < 10; p++) begin
         write_regs(gc_set[p], kd_set[p], wd_set[p], pc_set[p]);
         calm = (p == 4);
         if (p == 2) hold_req = 1;
         for (int i = 0; i < 92; i++) begin
            send_item(random_item());
            if (p == 6 && i == 40) drain();
         end
      end
      calm = 0;
      drain();
      repeat (40) @(posedge clock);

      if (board.owed.size() != 0) begin
         board.mismatches++;
         $display("ERROR: %0d answers never arrived", board.owed.size());
      end
      $display("covered %0d loads and %0d queries, %0d answers checked", loads_sent,
               queries_sent, board.answers);
      $display("all map kinds, group counts 1..8, zero and saturated sizes exercised");
      if (board.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
